// File: design/lpt_pkg.sv
`default_nettype none
package lpt_pkg;
  localparam int NodeCount = 4096;
  localparam int NodeBits = 12;
  localparam int AddrBits = 128;
  localparam int DepthBits = 8;
  localparam int LabelBits = 16;
  localparam int QueueDepth = 2;

  localparam logic [LabelBits-1:0] NoLabel = '1;
  localparam logic [NodeBits-1:0] NullNode = '0;

  typedef enum logic {
    ActLookup = 1'b0,
    ActInsert = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  pfx_len;
    logic signed [15:0] location_id;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic signed [15:0] match_id;
    logic [7:0]  match_length;
    logic        pool_full;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic                 is_insert;
    logic                 skip;
    logic [AddrBits-1:0]  addr;
    logic [DepthBits-1:0] plen;
    logic [LabelBits-1:0] label;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StStep,
    StLabel,
    StDone,
    StInit,
    StAlloc
  } walk_state_e;
endpackage
`default_nettype wire

// File: design/ipv6_longest_prefix_trie_top.sv
// IPv6 longest-prefix trie, one address bit per level, in a 4096-node pool.
// Input channel in_valid_i/in_stall_o carries in_data_i: action, address halves,
// prefix length and location id. Output channel out_valid_o/out_stall_i carries one
// result beat per input beat: found, match id, match length, pool full.
// A two-entry command queue decouples acceptance from the walk; the walk handles
// one command at a time.
// A lookup reads one node per level along its path and stops at /128 or a null
// child; an insert walks its path, allocating and clearing each missing node,
// then writes the label, or stops with pool full when no node is free; an insert
// longer than /128 skips the walk. The node pool's single read port serves the
// walk, and the next command starts once the current result has moved to the
// output register.
// Reset empties the trie; the init state after reset clears the root node, and
// other nodes are cleared when allocated.
// When the receiver stalls, the result beat holds and the walk waits at its end;
// the queue keeps accepting until it is full.
`default_nettype none
module ipv6_longest_prefix_trie_top
  import lpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  lpt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  lpt_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire

// File: design/lpt_front.sv
`default_nettype none
module lpt_front
  import lpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_pop_i,
  output cmd_t          cmd_o
);
  localparam int PtrBits = $clog2(QueueDepth);

  cmd_t               mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrBits:0]   cnt_q, cnt_d;
  logic               push;
  cmd_t               cmd_new;

  always_comb begin
    cmd_new.is_insert = (in_data_i.action == ActInsert);
    cmd_new.skip      = cmd_new.is_insert && (in_data_i.pfx_len > 8'(AddrBits));
    cmd_new.addr      = {in_data_i.addr_high, in_data_i.addr_low};
    cmd_new.plen      = in_data_i.pfx_len;
    cmd_new.label     = in_data_i.location_id;
  end

  assign in_stall_o  = (cnt_q == (PtrBits+1)'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = cmd_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(QueueDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrBits+1)'(QueueDepth)) |-> in_stall_o) else $error("full not stalled");
endmodule
`default_nettype wire

// File: design/lpt_back.sv
`default_nettype none
module lpt_back
  import lpt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_pop_o,
  input  wire cmd_t  cmd_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output out_item_t  out_data_o
);
  // Node pool: children and labels, read one node per step.
  logic [NodeBits-1:0]  zc_mem [NodeCount];
  logic [NodeBits-1:0]  oc_mem [NodeCount];
  logic [LabelBits-1:0] lb_mem [NodeCount];
  logic [NodeBits-1:0]  zc_rd, oc_rd;
  logic [LabelBits-1:0] lb_rd;

  walk_state_e          state_q, state_d;
  cmd_t                 cmd_q;
  logic [NodeBits-1:0]  cur_q, cur_d;
  logic [DepthBits-1:0] depth_q, depth_d;
  logic [NodeBits:0]    free_q, free_d;
  logic                 hit_q, hit_d;
  logic [LabelBits-1:0] best_q, best_d;
  logic [DepthBits-1:0] blen_q, blen_d;
  logic                 full_q, full_d;
  logic                 ovalid_q;
  out_item_t            odata_q;

  logic                 bit_cur, take_cmd, finish;
  logic [NodeBits-1:0]  child;
  logic                 lb_we, ch_we, clr_we;
  logic [NodeBits-1:0]  fresh;

  assign bit_cur  = cmd_q.addr[7'(AddrBits - 1) - depth_q[6:0]];
  assign child    = bit_cur ? oc_rd : zc_rd;
  assign fresh    = free_q[NodeBits-1:0];
  assign take_cmd = (state_q == StIdle) && cmd_valid_i;
  assign cmd_pop_o = take_cmd;
  assign finish   = (state_q == StDone) && !(ovalid_q && out_stall_i);
  // Clear the node at cur_q: the root after reset, a fresh node after allocation.
  assign clr_we   = (state_q == StInit) || (state_q == StAlloc);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StInit:  state_d = StIdle;
      StIdle:  if (cmd_valid_i) state_d = cmd_i.skip ? StDone : StRead;
      StRead:  state_d = StStep;
      StStep: begin
        if (cmd_q.is_insert) begin
          if (depth_q == cmd_q.plen) state_d = StLabel;
          else if (child == NullNode) begin
            if (free_q >= (NodeBits+1)'(NodeCount)) state_d = StDone;
            else state_d = StAlloc;
          end else state_d = StRead;
        end else begin
          if (depth_q == 8'(AddrBits) || child == NullNode) state_d = StDone;
          else state_d = StRead;
        end
      end
      StAlloc: state_d = StRead;
      StLabel: state_d = StDone;
      StDone:  if (finish) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and memory write controls.
  always_comb begin
    cur_d    = cur_q;
    depth_d  = depth_q;
    free_d   = free_q;
    hit_d    = hit_q;
    best_d   = best_q;
    blen_d   = blen_q;
    full_d   = full_q;
    lb_we    = 1'b0;
    ch_we    = 1'b0;
    case (state_q)
      StIdle: begin
        cur_d   = NullNode;
        depth_d = '0;
        hit_d   = 1'b0;
        best_d  = NoLabel;
        blen_d  = '0;
        full_d  = 1'b0;
      end
      StStep: begin
        if (!cmd_q.is_insert && lb_rd != NoLabel) begin
          hit_d  = 1'b1;
          best_d = lb_rd;
          blen_d = depth_q;
        end
        if (cmd_q.is_insert && depth_q != cmd_q.plen) begin
          if (child == NullNode) begin
            if (free_q >= (NodeBits+1)'(NodeCount)) begin
              full_d = 1'b1;
            end else begin
              ch_we    = 1'b1;
              free_d   = free_q + 1'b1;
              cur_d    = fresh;
              depth_d  = depth_q + 1'b1;
            end
          end else begin
            cur_d   = child;
            depth_d = depth_q + 1'b1;
          end
        end else if (!cmd_q.is_insert && depth_q != 8'(AddrBits) && child != NullNode) begin
          cur_d   = child;
          depth_d = depth_q + 1'b1;
        end
      end
      StLabel: lb_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    zc_rd <= zc_mem[cur_q];
    oc_rd <= oc_mem[cur_q];
    lb_rd <= lb_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (clr_we)                zc_mem[cur_q] <= NullNode;
    else if (ch_we && !bit_cur) zc_mem[cur_q] <= fresh;
  end

  always_ff @(posedge clk_i) begin
    if (clr_we)               oc_mem[cur_q] <= NullNode;
    else if (ch_we && bit_cur) oc_mem[cur_q] <= fresh;
  end

  always_ff @(posedge clk_i) begin
    if (clr_we)     lb_mem[cur_q] <= NoLabel;
    else if (lb_we) lb_mem[cur_q] <= cmd_q.label;
  end

  always_ff @(posedge clk_i) begin
    if (take_cmd) cmd_q <= cmd_i;
    if (state_q == StStep && state_d == StDone || state_q == StLabel) begin
      odata_q.found        <= hit_d;
      odata_q.match_id     <= hit_d ? best_d : NoLabel;
      odata_q.match_length <= hit_d ? blen_d : '0;
      odata_q.pool_full    <= full_d;
    end else if (take_cmd && cmd_i.skip) begin
      odata_q <= '{found: 1'b0, match_id: NoLabel, match_length: '0, pool_full: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      ovalid_q <= 1'b0;
      cur_q    <= NullNode;
      depth_q  <= '0;
      free_q   <= (NodeBits+1)'(1);
      hit_q    <= 1'b0;
      best_q   <= NoLabel;
      blen_q   <= '0;
      full_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      depth_q  <= depth_d;
      free_q   <= free_d;
      hit_q    <= hit_d;
      best_q   <= best_d;
      blen_q   <= blen_d;
      full_q   <= full_d;
      if (finish) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // Register the beat into hold_q when the walk finishes, in step with out_valid_o.
  out_item_t hold_q;
  always_ff @(posedge clk_i) begin
    if (finish) hold_q <= odata_q;
  end
  assign out_valid_o = ovalid_q;
  assign out_data_o  = hold_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= (NodeBits+1)'(NodeCount)) else $error("free pointer overrun");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == StIdle) else $error("pop while busy");
  a_alloc_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_we |=> free_q == $past(free_q) + 1'b1) else $error("alloc without advance");
endmodule
`default_nettype wire
